// ===== hdl/cpl_pkg.sv =====
// ----------------------------------------------------------------------------
// cpl_pkg: shared types, codes and character helpers of the token lexer
// Token and bundle layouts, lexer mode codes, token kinds, punctuator tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cpl_pkg;

  localparam int IDX_W   = 24;
  localparam int LINE_W  = 20;
  localparam int COL_W   = 16;
  localparam int KIND_W  = 4;
  localparam int PUNCT_W = 6;
  localparam int MODE_W  = 4;
  localparam int PP_W    = 4;
  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // lexer modes
  localparam logic [MODE_W-1:0] M_IDLE      = 4'd0;
  localparam logic [MODE_W-1:0] M_WS        = 4'd1;
  localparam logic [MODE_W-1:0] M_SLASH     = 4'd2;
  localparam logic [MODE_W-1:0] M_LCOM      = 4'd3;
  localparam logic [MODE_W-1:0] M_BCOM      = 4'd4;
  localparam logic [MODE_W-1:0] M_BCOM_STAR = 4'd5;
  localparam logic [MODE_W-1:0] M_STR       = 4'd6;
  localparam logic [MODE_W-1:0] M_NUM       = 4'd7;
  localparam logic [MODE_W-1:0] M_NUM_EXP   = 4'd8;
  localparam logic [MODE_W-1:0] M_IDENT     = 4'd9;
  localparam logic [MODE_W-1:0] M_PUNCT     = 4'd10;
  localparam logic [MODE_W-1:0] M_DOT1      = 4'd11;
  localparam logic [MODE_W-1:0] M_DOT2      = 4'd12;
  localparam logic [MODE_W-1:0] M_BSL       = 4'd13;

  // token kinds
  localparam logic [KIND_W-1:0] K_EOF   = 4'd0;
  localparam logic [KIND_W-1:0] K_DIR   = 4'd1;
  localparam logic [KIND_W-1:0] K_IDENT = 4'd2;
  localparam logic [KIND_W-1:0] K_NUM   = 4'd3;
  localparam logic [KIND_W-1:0] K_STR   = 4'd4;
  localparam logic [KIND_W-1:0] K_PUNCT = 4'd5;
  localparam logic [KIND_W-1:0] K_NL    = 4'd6;
  localparam logic [KIND_W-1:0] K_WS    = 4'd7;
  localparam logic [KIND_W-1:0] K_COM   = 4'd8;
  localparam logic [KIND_W-1:0] K_OTHER = 4'd9;

  // punctuator codes named in the lexer
  localparam logic [PUNCT_W-1:0] P_NONE     = 6'd0;
  localparam logic [PUNCT_W-1:0] P_ELLIPSIS = 6'd11;
  localparam logic [PUNCT_W-1:0] P_DOT      = 6'd12;
  localparam logic [PUNCT_W-1:0] P_DIV_EQ   = 6'd43;
  localparam logic [PUNCT_W-1:0] P_DIV      = 6'd44;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UND   = 8'h5F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  typedef struct packed {
    logic [COL_W-1:0]   start_column;
    logic [LINE_W-1:0]  start_line;
    logic [IDX_W-1:0]   token_length;
    logic [IDX_W-1:0]   start_index;
    logic [PUNCT_W-1:0] punct_kind;
    logic [KIND_W-1:0]  token_kind;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RES-1:0] tok;
    logic [CNT_W-1:0]   cnt;
  } bundle_t;

  typedef struct packed {
    logic               hit;
    logic               cont;
    logic [PUNCT_W-1:0] code;
  } pext_t;

  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_W-1:0] sat_line(input logic [LINE_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UND);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return (c == 8'h65) || (c == 8'h45) || (c == 8'h70) || (c == 8'h50);
  endfunction

  function automatic logic [PUNCT_W-1:0] single_punct(input logic [7:0] c);
    logic [PUNCT_W-1:0] r;
    unique case (c)
      8'h3F:   r = 6'd1;
      8'h28:   r = 6'd2;
      8'h29:   r = 6'd3;
      8'h5B:   r = 6'd4;
      8'h5D:   r = 6'd5;
      8'h7B:   r = 6'd6;
      8'h7D:   r = 6'd7;
      8'h3A:   r = 6'd8;
      8'h3B:   r = 6'd9;
      8'h2C:   r = 6'd10;
      8'h7E:   r = 6'd21;
      default: r = P_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [PP_W-1:0] punct_starter(input logic [7:0] c);
    logic [PP_W-1:0] r;
    unique case (c)
      CH_GT:    r = 4'd1;
      CH_LT:    r = 4'd3;
      8'h21:    r = 4'd5;
      CH_EQ:    r = 4'd6;
      CH_AMP:   r = 4'd7;
      CH_BAR:   r = 4'd8;
      8'h5E:    r = 4'd9;
      CH_PLUS:  r = 4'd10;
      CH_MINUS: r = 4'd11;
      CH_STAR:  r = 4'd12;
      8'h25:    r = 4'd13;
      default:  r = '0;
    endcase
    return r;
  endfunction

  // code of a held prefix when the next byte does not extend it
  function automatic logic [PUNCT_W-1:0] punct_short(input logic [PP_W-1:0] p);
    logic [PUNCT_W-1:0] r;
    unique case (p)
      4'd1:    r = 6'd16;
      4'd2:    r = 6'd15;
      4'd3:    r = 6'd20;
      4'd4:    r = 6'd19;
      4'd5:    r = 6'd23;
      4'd6:    r = 6'd25;
      4'd7:    r = 6'd28;
      4'd8:    r = 6'd31;
      4'd9:    r = 6'd33;
      4'd10:   r = 6'd36;
      4'd11:   r = 6'd40;
      4'd12:   r = 6'd42;
      4'd13:   r = 6'd46;
      default: r = P_NONE;
    endcase
    return r;
  endfunction

  // extension of a held prefix by byte c
  function automatic pext_t punct_ext(input logic [PP_W-1:0] p, input logic [7:0] c);
    pext_t r;
    r = '0;
    unique case (p)
      4'd1: begin
        if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd13};
        else if (c == CH_GT) r = '{1'b1, 1'b1, 6'd2};
      end
      4'd2: if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd14};
      4'd3: begin
        if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd17};
        else if (c == CH_LT) r = '{1'b1, 1'b1, 6'd4};
      end
      4'd4:  if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd18};
      4'd5:  if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd22};
      4'd6:  if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd24};
      4'd7: begin
        if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd26};
        else if (c == CH_AMP) r = '{1'b1, 1'b0, 6'd27};
      end
      4'd8: begin
        if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd29};
        else if (c == CH_BAR) r = '{1'b1, 1'b0, 6'd30};
      end
      4'd9: if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd32};
      4'd10: begin
        if (c == CH_PLUS) r = '{1'b1, 1'b0, 6'd34};
        else if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd35};
      end
      4'd11: begin
        if (c == CH_MINUS) r = '{1'b1, 1'b0, 6'd37};
        else if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd38};
        else if (c == CH_GT) r = '{1'b1, 1'b0, 6'd39};
      end
      4'd12:   if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd41};
      4'd13:   if (c == CH_EQ) r = '{1'b1, 1'b0, 6'd45};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                  input logic [PUNCT_W-1:0] punct,
                                  input logic [IDX_W-1:0] si,
                                  input logic [LINE_W-1:0] sl,
                                  input logic [COL_W-1:0] sc,
                                  input logic [IDX_W-1:0] end_idx);
    tok_t t;
    t.token_kind   = kind;
    t.punct_kind   = punct;
    t.start_index  = si;
    t.token_length = (end_idx >= si) ? end_idx - si : '0;
    t.start_line   = sl;
    t.start_column = sc;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cpl_front.sv =====
// ----------------------------------------------------------------------------
// cpl_front: character classifier and lexer state
// Takes one byte per transaction and produces a bundle of up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  wire [7:0]        ch,
  input  wire              is_end,
  input  wire              angle_mode,
  output logic             push,
  output cpl_pkg::bundle_t bundle
);
  import cpl_pkg::*;

  logic [MODE_W-1:0] lex_mode, lex_mode_next;
  logic [PP_W-1:0]   punct_progress, punct_progress_next;
  logic [IDX_W-1:0]  tok_si, tok_si_next, cur_idx;
  logic [LINE_W-1:0] tok_sl, tok_sl_next, src_line;
  logic [COL_W-1:0]  tok_sc, tok_sc_next, cur_col;
  logic              line_seen, line_seen_next;
  logic              escape, escape_next;
  logic [7:0]        closer, closer_next;
  logic              angle, angle_next;

  logic [IDX_W-1:0]   ni, e_end;
  logic [CNT_W-1:0]   n;
  tok_t [MAX_RES-1:0] tk;
  logic               done, e_do, shift, was_seen;
  logic [KIND_W-1:0]  e_kind;
  logic [PUNCT_W-1:0] e_punct, sp;
  logic [PP_W-1:0]    ps;
  pext_t              ext;

  // step the lexer through up to three mode changes for this byte
  always_comb begin
    lex_mode_next       = lex_mode;
    punct_progress_next = punct_progress;
    tok_si_next         = tok_si;
    tok_sl_next         = tok_sl;
    tok_sc_next         = tok_sc;
    line_seen_next      = line_seen;
    escape_next         = escape;
    closer_next         = closer;
    angle_next          = angle;
    ni       = sat_idx(cur_idx);
    n        = '0;
    tk       = '0;
    done     = 1'b0;
    e_do     = 1'b0;
    e_kind   = K_OTHER;
    e_punct  = P_NONE;
    e_end    = cur_idx;
    shift    = 1'b0;
    was_seen = 1'b0;
    ext      = '0;
    sp       = P_NONE;
    ps       = '0;
    if (is_end) begin
      // flush the held token
      unique case (lex_mode_next)
        M_WS: begin
          tk[n] = mk_tok(K_WS, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_SLASH: begin
          tk[n] = mk_tok(K_PUNCT, P_DIV, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_LCOM, M_BCOM, M_BCOM_STAR: begin
          tk[n] = mk_tok(K_COM, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_STR: begin
          tk[n] = mk_tok(K_STR, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_NUM, M_NUM_EXP: begin
          tk[n] = mk_tok(K_NUM, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_IDENT: begin
          tk[n] = mk_tok(K_IDENT, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_PUNCT: begin
          sp = punct_short(punct_progress_next);
          tk[n] = mk_tok((sp == P_NONE) ? K_OTHER : K_PUNCT, sp,
                         tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_DOT1: begin
          tk[n] = mk_tok(K_PUNCT, P_DOT, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_DOT2: begin
          tk[n] = mk_tok(K_PUNCT, P_DOT, tok_si_next, tok_sl_next, tok_sc_next,
                         sat_idx(tok_si_next));
          n = n + 1'b1;
          tok_si_next = sat_idx(tok_si_next);
          tok_sc_next = sat_col(tok_sc_next);
          tk[n] = mk_tok(K_PUNCT, P_DOT, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        M_BSL: begin
          tk[n] = mk_tok(K_OTHER, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
          n = n + 1'b1;
        end
        default: ;
      endcase
      lex_mode_next       = M_IDLE;
      punct_progress_next = '0;
      escape_next         = 1'b0;
      tok_si_next = cur_idx;
      tok_sl_next = src_line;
      tok_sc_next = cur_col;
      tk[n] = mk_tok(K_EOF, P_NONE, tok_si_next, tok_sl_next, tok_sc_next, cur_idx);
      n = n + 1'b1;
    end else begin
      if (angle_mode) angle_next = 1'b1;
      for (int it = 0; it < MAX_RES; it++) begin
        if (!done) begin
          e_do    = 1'b0;
          e_kind  = K_OTHER;
          e_punct = P_NONE;
          e_end   = cur_idx;
          shift   = 1'b0;
          unique case (lex_mode_next)
            M_WS: begin
              if (is_blank(ch)) done = 1'b1;
              else begin
                e_do = 1'b1; e_kind = K_WS; lex_mode_next = M_IDLE;
              end
            end
            M_SLASH: begin
              priority if (ch == CH_SLASH) begin
                lex_mode_next = M_LCOM; done = 1'b1;
              end else if (ch == CH_STAR) begin
                lex_mode_next = M_BCOM; done = 1'b1;
              end else if (ch == CH_EQ) begin
                e_do = 1'b1; e_kind = K_PUNCT; e_punct = P_DIV_EQ; e_end = ni;
                lex_mode_next = M_IDLE; done = 1'b1;
              end else begin
                e_do = 1'b1; e_kind = K_PUNCT; e_punct = P_DIV; lex_mode_next = M_IDLE;
              end
            end
            M_LCOM: begin
              if (ch != CH_NL) done = 1'b1;
              else begin
                e_do = 1'b1; e_kind = K_COM; lex_mode_next = M_IDLE;
              end
            end
            M_BCOM: begin
              if (ch == CH_STAR) lex_mode_next = M_BCOM_STAR;
              done = 1'b1;
            end
            M_BCOM_STAR: begin
              if (ch == CH_SLASH) begin
                e_do = 1'b1; e_kind = K_COM; e_end = ni; lex_mode_next = M_IDLE;
              end else if (ch != CH_STAR) lex_mode_next = M_BCOM;
              done = 1'b1;
            end
            M_STR: begin
              if (!escape_next && ch == closer_next) begin
                e_do = 1'b1; e_kind = K_STR; e_end = ni;
                lex_mode_next = M_IDLE; escape_next = 1'b0;
              end else escape_next = !escape_next && (ch == CH_BSL);
              done = 1'b1;
            end
            M_NUM, M_NUM_EXP: begin
              priority if (lex_mode_next == M_NUM_EXP && (ch == CH_PLUS || ch == CH_MINUS))
              begin
                lex_mode_next = M_NUM; done = 1'b1;
              end else if (is_ident(ch) || ch == CH_DOT) begin
                lex_mode_next = is_exp(ch) ? M_NUM_EXP : M_NUM; done = 1'b1;
              end else begin
                e_do = 1'b1; e_kind = K_NUM; lex_mode_next = M_IDLE;
              end
            end
            M_IDENT: begin
              if (is_ident(ch)) done = 1'b1;
              else begin
                e_do = 1'b1; e_kind = K_IDENT; lex_mode_next = M_IDLE;
              end
            end
            M_PUNCT: begin
              ext = punct_ext(punct_progress_next, ch);
              if (ext.hit) begin
                if (ext.cont) punct_progress_next = ext.code[PP_W-1:0];
                else begin
                  e_do = 1'b1; e_kind = K_PUNCT; e_punct = ext.code; e_end = ni;
                  lex_mode_next = M_IDLE; punct_progress_next = '0;
                end
                done = 1'b1;
              end else begin
                e_punct = punct_short(punct_progress_next);
                e_do = 1'b1; e_kind = (e_punct == P_NONE) ? K_OTHER : K_PUNCT;
                punct_progress_next = '0; lex_mode_next = M_IDLE;
              end
            end
            M_DOT1: begin
              priority if (is_digit(ch)) begin
                lex_mode_next = M_NUM; done = 1'b1;
              end else if (ch == CH_DOT) begin
                lex_mode_next = M_DOT2; done = 1'b1;
              end else begin
                e_do = 1'b1; e_kind = K_PUNCT; e_punct = P_DOT; lex_mode_next = M_IDLE;
              end
            end
            M_DOT2: begin
              if (ch == CH_DOT) begin
                e_do = 1'b1; e_kind = K_PUNCT; e_punct = P_ELLIPSIS; e_end = ni;
                lex_mode_next = M_IDLE; done = 1'b1;
              end else begin
                // emit the first dot, keep the second as a held dot
                e_do = 1'b1; e_kind = K_PUNCT; e_punct = P_DOT; e_end = sat_idx(tok_si_next);
                shift = 1'b1; lex_mode_next = M_DOT1;
              end
            end
            M_BSL: begin
              if (ch == CH_NL) begin
                lex_mode_next = M_IDLE; done = 1'b1;
              end else begin
                line_seen_next = 1'b1;
                e_do = 1'b1; e_kind = K_OTHER; lex_mode_next = M_IDLE;
              end
            end
            default: begin
              // start a new token with this byte
              lex_mode_next = M_IDLE;
              done = 1'b1;
              tok_si_next = cur_idx;
              tok_sl_next = src_line;
              tok_sc_next = cur_col;
              sp = single_punct(ch);
              ps = punct_starter(ch);
              priority if (ch == CH_BSL) lex_mode_next = M_BSL;
              else if (ch == CH_NL) begin
                e_do = 1'b1; e_kind = K_NL; e_end = ni;
                line_seen_next = 1'b0; angle_next = 1'b0;
              end else if (is_blank(ch)) lex_mode_next = M_WS;
              else begin
                was_seen = line_seen_next;
                line_seen_next = 1'b1;
                priority if (ch == CH_SLASH) lex_mode_next = M_SLASH;
                else if (ch == CH_DQ || ch == CH_SQ || (ch == CH_LT && angle_next)) begin
                  lex_mode_next = M_STR;
                  closer_next = (ch == CH_LT) ? CH_GT : ch;
                  escape_next = 1'b0;
                end else if (ch == CH_HASH && !was_seen) begin
                  e_do = 1'b1; e_kind = K_DIR; e_end = ni;
                end else if (is_digit(ch)) lex_mode_next = M_NUM;
                else if (ch == CH_DOT) lex_mode_next = M_DOT1;
                else if (sp != P_NONE) begin
                  e_do = 1'b1; e_kind = K_PUNCT; e_punct = sp; e_end = ni;
                end else if (ps != '0) begin
                  lex_mode_next = M_PUNCT; punct_progress_next = ps;
                end else if (is_alpha(ch) || ch == CH_UND) lex_mode_next = M_IDENT;
                else begin
                  e_do = 1'b1; e_kind = K_OTHER; e_end = ni;
                end
              end
            end
          endcase
          if (e_do && n != 2'd3) begin
            tk[n] = mk_tok(e_kind, e_punct, tok_si_next, tok_sl_next, tok_sc_next, e_end);
            n = n + 1'b1;
          end
          if (shift) begin
            tok_si_next = sat_idx(tok_si_next);
            tok_sc_next = sat_col(tok_sc_next);
          end
        end
      end
    end
  end

  assign push       = accept && (n != '0);
  assign bundle.tok = tk;
  assign bundle.cnt = n;

  // advance lexer state and source position on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= M_IDLE;
      punct_progress <= '0;
      tok_si         <= '0;
      tok_sl         <= '0;
      tok_sc         <= '0;
      cur_idx        <= '0;
      src_line       <= '0;
      cur_col        <= '0;
      line_seen      <= 1'b0;
      escape         <= 1'b0;
      closer         <= '0;
      angle          <= 1'b0;
    end else if (accept) begin
      lex_mode       <= lex_mode_next;
      punct_progress <= punct_progress_next;
      tok_si         <= tok_si_next;
      tok_sl         <= tok_sl_next;
      tok_sc         <= tok_sc_next;
      line_seen      <= line_seen_next;
      escape         <= escape_next;
      closer         <= closer_next;
      angle          <= angle_next;
      if (!is_end) begin
        cur_idx <= ni;
        if (ch == CH_NL) begin
          src_line <= sat_line(src_line);
          cur_col  <= '0;
        end else begin
          cur_col <= sat_col(cur_col);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cpl_queue.sv =====
// ----------------------------------------------------------------------------
// cpl_queue: token bundle queue
// Four-entry queue that decouples the lexer from the token serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  cpl_pkg::bundle_t push_data,
  output logic             full,
  input  wire              pop,
  output cpl_pkg::bundle_t pop_data,
  output logic             empty
);
  import cpl_pkg::*;

  bundle_t         mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign full     = (count == Q_DEPTH[Q_AW:0]);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // store pushed bundles
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cpl_back.sv =====
// ----------------------------------------------------------------------------
// cpl_back: token serializer
// Unpacks queued bundles into one token transaction per cycle while m_tready is high, with tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_back (
  input  wire              clk,
  input  wire              rst,
  input  cpl_pkg::bundle_t q_data,
  input  wire              q_empty,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [95:0]      m_tdata,
  output logic             m_tlast
);
  import cpl_pkg::*;

  bundle_t          bun;
  logic             have;
  logic [CNT_W-1:0] idx;
  logic             load;

  assign m_tvalid = have;
  assign m_tlast  = (idx == bun.cnt - 1'b1);
  assign m_tdata  = {2'b00, bun.tok[idx]};
  assign load     = !have || (m_tready && m_tlast);
  assign q_pop    = load && !q_empty;

  // hold the current bundle, step through its tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      have <= !q_empty;
      idx  <= '0;
    end else if (m_tready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) bun <= q_data;
  end

endmodule

`default_nettype wire

// ===== hdl/c_preprocessing_token_lexer.sv =====
// ----------------------------------------------------------------------------
// c_preprocessing_token_lexer: C preprocessing token lexer, top level
// Channel   Dir  Payload
// s_*       in   tdata[7:0] ch; tuser[0] is_end, tuser[1] angle_mode
// m_*       out  tdata token fields (see port), tlast last token of a byte
// One source byte is taken per cycle while the four-bundle queue has room.
// Each byte yields zero to three tokens; tokens leave one per cycle while
// m_tready is high.
// Synchronous reset clears the lexer state, the queue and the output stage.
// Output stalls back up through the queue to s_tready only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module c_preprocessing_token_lexer (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,  // ch
  input  wire  [1:0]  s_tuser,  // is_end, angle_mode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [95:0] m_tdata,  // token_kind, punct_kind, start_index,
                                // token_length, start_line, start_column
  output logic        m_tlast
);
  import cpl_pkg::*;

  logic    full, empty, push, pop;
  bundle_t push_data, pop_data;

  assign s_tready = !full;

  cpl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_tvalid && s_tready),
    .ch         (s_tdata),
    .is_end     (s_tuser[0]),
    .angle_mode (s_tuser[1]),
    .push       (push),
    .bundle     (push_data)
  );

  cpl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cpl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (pop_data),
    .q_empty  (empty),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/cpl_checker.sv =====
// ----------------------------------------------------------------------------
// cpl_checker: port-level checks of the token lexer
// Output stall behavior and token field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module cpl_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [95:0] m_tdata,
  input wire        m_tlast
);
  import cpl_pkg::*;

  // hold a stalled token
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled token changed");

  // kind stays within the defined codes
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= K_OTHER)
    else $error("bad token kind");

  // punctuator code only on punctuators
  a_punct: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9:4] != P_NONE |-> m_tdata[3:0] == K_PUNCT)
    else $error("punctuator code on non-punctuator");

  // end-of-file token is empty and closes its transaction group
  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3:0] == K_EOF |-> m_tlast && m_tdata[57:34] == 24'd0)
    else $error("malformed end-of-file token");

endmodule

bind c_preprocessing_token_lexer cpl_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/c_preprocessing_token_lexer_tb.sv =====
// ----------------------------------------------------------------------------
// c_preprocessing_token_lexer_tb: self-checking bench of the token lexer
// Streams source bytes into the lexer and predicts every token in the bench.
// Each output transaction is checked in order against the predicted tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c_preprocessing_token_lexer_tb;
  import cpl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [LINE_W-1:0]  line;
    logic [IDX_W-1:0]   len;
    logic [IDX_W-1:0]   idx;
    logic [PUNCT_W-1:0] punct;
    logic [KIND_W-1:0]  kind;
    logic               last;
  } token_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tlast;

  token_t      token_queue[$];
  int          errors;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  // predictor state
  logic [MODE_W-1:0] mode;
  logic [PP_W-1:0]   prog;
  logic [IDX_W-1:0]  tok_idx, cur_idx;
  logic [LINE_W-1:0] tok_line, src_line;
  logic [COL_W-1:0]  tok_col, cur_col;
  logic              line_seen, esc, angle;
  logic [7:0]        closer;
  int                step_count;

  c_preprocessing_token_lexer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // emit one predicted token, capped at three per byte
  task automatic push_token(input logic [KIND_W-1:0] k, input logic [PUNCT_W-1:0] p,
                            input logic [IDX_W-1:0] end_idx);
    token_t t;
    if (step_count >= MAX_RES) return;
    t.kind  = k;
    t.punct = p;
    t.idx   = tok_idx;
    t.len   = (end_idx >= tok_idx) ? end_idx - tok_idx : '0;
    t.line  = tok_line;
    t.col   = tok_col;
    t.last  = 1'b0;
    token_queue.push_back(t);
    step_count++;
  endtask

  task automatic push_code(input logic [PUNCT_W-1:0] p, input logic [IDX_W-1:0] e);
    if (p == P_NONE) push_token(K_OTHER, P_NONE, e);
    else push_token(K_PUNCT, p, e);
  endtask

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [COL_W-1:0] inc_col(input logic [COL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // longest-match table of multi-byte punctuators: hit, continue, code
  function automatic logic [7:0] ext_lookup(input logic [PP_W-1:0] p, input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (p)
      4'd1:  if (c == ">") r = {2'b11, 6'd2}; else if (c == "=") r = {2'b10, 6'd13};
      4'd2:  if (c == "=") r = {2'b10, 6'd14};
      4'd3:  if (c == "<") r = {2'b11, 6'd4}; else if (c == "=") r = {2'b10, 6'd17};
      4'd4:  if (c == "=") r = {2'b10, 6'd18};
      4'd5:  if (c == "=") r = {2'b10, 6'd22};
      4'd6:  if (c == "=") r = {2'b10, 6'd24};
      4'd7:  if (c == "=") r = {2'b10, 6'd26}; else if (c == "&") r = {2'b10, 6'd27};
      4'd8:  if (c == "=") r = {2'b10, 6'd29}; else if (c == "|") r = {2'b10, 6'd30};
      4'd9:  if (c == "=") r = {2'b10, 6'd32};
      4'd10: if (c == "+") r = {2'b10, 6'd34}; else if (c == "=") r = {2'b10, 6'd35};
      4'd11: if (c == "-") r = {2'b10, 6'd37}; else if (c == "=") r = {2'b10, 6'd38};
             else if (c == ">") r = {2'b10, 6'd39};
      4'd12: if (c == "=") r = {2'b10, 6'd41};
      4'd13: if (c == "=") r = {2'b10, 6'd45};
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [PUNCT_W-1:0] short_code(input logic [PP_W-1:0] p);
    case (p)
      4'd1: return 6'd16;  4'd2: return 6'd15;  4'd3: return 6'd20;
      4'd4: return 6'd19;  4'd5: return 6'd23;  4'd6: return 6'd25;
      4'd7: return 6'd28;  4'd8: return 6'd31;  4'd9: return 6'd33;
      4'd10: return 6'd36; 4'd11: return 6'd40; 4'd12: return 6'd42;
      4'd13: return 6'd46;
      default: return P_NONE;
    endcase
  endfunction

  function automatic logic [PUNCT_W-1:0] lone_code(input logic [7:0] c);
    case (c)
      "?": return 6'd1;  "(": return 6'd2;  ")": return 6'd3;  "[": return 6'd4;
      "]": return 6'd5;  "{": return 6'd6;  "}": return 6'd7;  ":": return 6'd8;
      ";": return 6'd9;  ",": return 6'd10; "~": return 6'd21;
      default: return P_NONE;
    endcase
  endfunction

  function automatic logic [PP_W-1:0] prefix_code(input logic [7:0] c);
    case (c)
      ">": return 4'd1;  "<": return 4'd3;  "!": return 4'd5;  "=": return 4'd6;
      "&": return 4'd7;  "|": return 4'd8;  "^": return 4'd9;  "+": return 4'd10;
      "-": return 4'd11; "*": return 4'd12; "%": return 4'd13;
      default: return '0;
    endcase
  endfunction

  function automatic logic c_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic c_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic c_word(input logic [7:0] c);
    return c_alpha(c) || c_digit(c) || c == "_";
  endfunction

  function automatic logic c_blank(input logic [7:0] c);
    return c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13;
  endfunction

  // open a new token with byte c
  task automatic open_token(input logic [7:0] c);
    logic seen;
    tok_idx = cur_idx; tok_line = src_line; tok_col = cur_col;
    mode = M_IDLE;
    if (c == CH_BSL) begin mode = M_BSL; return; end
    if (c == CH_NL) begin
      push_token(K_NL, P_NONE, inc_idx(cur_idx));
      line_seen = 1'b0; angle = 1'b0;
      return;
    end
    if (c_blank(c)) begin mode = M_WS; return; end
    seen = line_seen;
    line_seen = 1'b1;
    if (c == CH_SLASH) begin mode = M_SLASH; return; end
    if (c == CH_DQ || c == CH_SQ || (c == CH_LT && angle)) begin
      mode = M_STR; closer = (c == CH_LT) ? CH_GT : c; esc = 1'b0;
      return;
    end
    if (c == CH_HASH && !seen) begin push_token(K_DIR, P_NONE, inc_idx(cur_idx)); return; end
    if (c_digit(c)) begin mode = M_NUM; return; end
    if (c == CH_DOT) begin mode = M_DOT1; return; end
    if (lone_code(c) != P_NONE) begin
      push_token(K_PUNCT, lone_code(c), inc_idx(cur_idx));
      return;
    end
    if (prefix_code(c) != '0) begin mode = M_PUNCT; prog = prefix_code(c); return; end
    if (c_alpha(c) || c == "_") begin mode = M_IDENT; return; end
    push_token(K_OTHER, P_NONE, inc_idx(cur_idx));
  endtask

  // advance the lexer by one byte; rerun when a held double dot gives up its first dot
  task automatic lex_byte(input logic [7:0] c);
    logic [7:0] e;
    logic again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (mode)
        M_WS: if (!c_blank(c)) begin push_token(K_WS, P_NONE, cur_idx); open_token(c); end
        M_SLASH:
          if (c == CH_SLASH) mode = M_LCOM;
          else if (c == CH_STAR) mode = M_BCOM;
          else if (c == CH_EQ) begin push_token(K_PUNCT, P_DIV_EQ, inc_idx(cur_idx)); mode = M_IDLE; end
          else begin push_token(K_PUNCT, P_DIV, cur_idx); open_token(c); end
        M_LCOM: if (c == CH_NL) begin push_token(K_COM, P_NONE, cur_idx); open_token(c); end
        M_BCOM: if (c == CH_STAR) mode = M_BCOM_STAR;
        M_BCOM_STAR:
          if (c == CH_SLASH) begin push_token(K_COM, P_NONE, inc_idx(cur_idx)); mode = M_IDLE; end
          else if (c != CH_STAR) mode = M_BCOM;
        M_STR:
          if (!esc && c == closer) begin
            push_token(K_STR, P_NONE, inc_idx(cur_idx)); mode = M_IDLE; esc = 1'b0;
          end else esc = !esc && c == CH_BSL;
        M_NUM, M_NUM_EXP:
          if (mode == M_NUM_EXP && (c == CH_PLUS || c == CH_MINUS)) mode = M_NUM;
          else if (c_word(c) || c == CH_DOT)
            mode = (c == "e" || c == "E" || c == "p" || c == "P") ? M_NUM_EXP : M_NUM;
          else begin push_token(K_NUM, P_NONE, cur_idx); open_token(c); end
        M_IDENT: if (!c_word(c)) begin push_token(K_IDENT, P_NONE, cur_idx); open_token(c); end
        M_PUNCT: begin
          e = ext_lookup(prog, c);
          if (e[7] && e[6]) prog = e[3:0];
          else if (e[7]) begin
            push_code(e[5:0], inc_idx(cur_idx)); mode = M_IDLE; prog = '0;
          end else begin
            push_code(short_code(prog), cur_idx); prog = '0; open_token(c);
          end
        end
        M_DOT1:
          if (c_digit(c)) mode = M_NUM;
          else if (c == CH_DOT) mode = M_DOT2;
          else begin push_token(K_PUNCT, P_DOT, cur_idx); open_token(c); end
        M_DOT2:
          if (c == CH_DOT) begin
            push_token(K_PUNCT, P_ELLIPSIS, inc_idx(cur_idx)); mode = M_IDLE;
          end else begin
            push_token(K_PUNCT, P_DOT, inc_idx(tok_idx));
            tok_idx = inc_idx(tok_idx); tok_col = inc_col(tok_col);
            mode = M_DOT1; again = 1'b1;
          end
        M_BSL:
          if (c == CH_NL) mode = M_IDLE;
          else begin line_seen = 1'b1; push_token(K_OTHER, P_NONE, cur_idx); open_token(c); end
        default: open_token(c);
      endcase
    end
  endtask

  // flush any held token at the end marker, then add the end-of-file token
  task automatic lex_end();
    case (mode)
      M_WS: push_token(K_WS, P_NONE, cur_idx);
      M_SLASH: push_token(K_PUNCT, P_DIV, cur_idx);
      M_LCOM, M_BCOM, M_BCOM_STAR: push_token(K_COM, P_NONE, cur_idx);
      M_STR: push_token(K_STR, P_NONE, cur_idx);
      M_NUM, M_NUM_EXP: push_token(K_NUM, P_NONE, cur_idx);
      M_IDENT: push_token(K_IDENT, P_NONE, cur_idx);
      M_PUNCT: push_code(short_code(prog), cur_idx);
      M_DOT1: push_token(K_PUNCT, P_DOT, cur_idx);
      M_DOT2: begin
        push_token(K_PUNCT, P_DOT, inc_idx(tok_idx));
        tok_idx = inc_idx(tok_idx); tok_col = inc_col(tok_col);
        push_token(K_PUNCT, P_DOT, cur_idx);
      end
      M_BSL: push_token(K_OTHER, P_NONE, cur_idx);
      default: ;
    endcase
    mode = M_IDLE; prog = '0; esc = 1'b0;
    tok_idx = cur_idx; tok_line = src_line; tok_col = cur_col;
    push_token(K_EOF, P_NONE, cur_idx);
  endtask

  task automatic predict(input logic [7:0] c, input logic fin, input logic ang);
    int base;
    base = token_queue.size();
    step_count = 0;
    if (fin) lex_end();
    else begin
      if (ang) angle = 1'b1;
      lex_byte(c);
      cur_idx = inc_idx(cur_idx);
      if (c == CH_NL) begin
        src_line = (&src_line) ? src_line : src_line + 1'b1;
        cur_col = '0;
      end else cur_col = inc_col(cur_col);
    end
    if (token_queue.size() > base) token_queue[token_queue.size() - 1].last = 1'b1;
  endtask

  // send one transaction and predict its tokens on acceptance
  task automatic send_byte(input logic [7:0] c, input logic fin = 1'b0,
                           input logic ang = 1'b0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= {ang, fin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(c, fin, ang);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each token against the oldest prediction
  always @(posedge clk) begin
    token_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[93:0], m_tlast};
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected token %h", $time, got);
        errors++;
      end else begin
        want = token_queue.pop_front();
        if (got.kind !== want.kind || got.punct !== want.punct || got.idx !== want.idx ||
            got.len !== want.len || got.line !== want.line || got.col !== want.col ||
            got.last !== want.last) begin
          $display("%0t: token mismatch expected k%0d p%0d i%0d n%0d l%0d c%0d t%0d",
                   $time, want.kind, want.punct, want.idx, want.len, want.line, want.col,
                   want.last);
          $display("%0t:                  actual k%0d p%0d i%0d n%0d l%0d c%0d t%0d",
                   $time, got.kind, got.punct, got.idx, got.len, got.line, got.col,
                   got.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // directed tokens of every kind and each corner case
  task automatic test_directed();
    send_text("#a ");
    send_text("/*/ x*/ ");
    send_text("//c\n");
    send_byte("<", 1'b0, 1'b1);
    send_text("h\\>>\n");
    send_text(".5e+1..\\\n");
    send_text(">>=<<=->...");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("\"a\\\"");
    send_byte(8'h00, 1'b1);
    send_text("..");
    send_byte(8'h00, 1'b1);
    drain();
  endtask

  // random streams of mostly well-formed C fragments plus noise
  task automatic test_random(input int n);
    string frag[$] = '{"int ", "x1_", "0x1Fp-3", "1.e+", "\"s\\n\"", "'\\''", "/*c*/",
                       "//r\n", "\n#if ", "a->b", "++", "&&", "|=", "^", "%=", "!=",
                       "==", "<<", ">=", "...", "?:", "[]{}", "(,;)~", "\\\n", "  \t",
                       "/=", "*=", "--", "<h.h>", "#", ".."};
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        string f;
        f = frag[$urandom_range(frag.size() - 1)];
        for (int i = 0; i < f.len(); i++)
          send_byte(f[i], 1'b0, $urandom_range(7) == 0);
        sent += f.len();
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(15) == 0,
                  1'($urandom_range(1)));
        sent++;
      end
    end
    send_byte(8'($urandom_range(255)), 1'b1);
    drain();
  endtask

  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
    errors = 0; cycles = 0; send_idle_pct = 27; recv_idle_pct = 68;
    mode = M_IDLE; prog = '0; tok_idx = '0; tok_line = '0; tok_col = '0;
    cur_idx = '0; src_line = '0; cur_col = '0;
    line_seen = 1'b0; esc = 1'b0; angle = 1'b0; closer = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(120);
    send_idle_pct = 68; recv_idle_pct = 27;
    test_random(120);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(120);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cpl_pkg.sv
hdl/cpl_front.sv
hdl/cpl_queue.sv
hdl/cpl_back.sv
hdl/c_preprocessing_token_lexer.sv
hdl/cpl_checker.sv
dv/c_preprocessing_token_lexer_tb.sv
